### hw/rtl/beat_pkg.sv
// Shared types and constants for the band energy adaptive trigger.
// Holds the item structs, configuration register indexes and fixed widths.
// Depends on nothing; every block file refers to it by scoped names.
`timescale 1ns / 1ps

package beat_pkg;

    localparam int MAG_W    = 16;
    localparam int SUM_W    = 22;
    localparam int THR_W    = 24;
    localparam int CMP_W    = THR_W + 2;
    localparam int IDX_W    = 4;
    localparam int MARGIN_W = 9;
    localparam int STEP_W   = 8;
    localparam int BPB_W    = 7;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 9;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic signed [CMP_W-1:0] THR_MAX = CMP_W'((1 << (THR_W - 1)) - 1);
    localparam logic signed [CMP_W-1:0] THR_MIN = -CMP_W'(1 << (THR_W - 1));

    localparam logic [MARGIN_W-1:0] MARGIN_RST = 9'd13;
    localparam logic [STEP_W-1:0]   STEP_RST   = 8'd3;
    localparam logic [BPB_W-1:0]    BPB_RST    = 7'd16;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MARGIN        = 2'd0,
        CFG_STEP          = 2'd1,
        CFG_BINS_PER_BAND = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } bin_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] band_index;
        logic [SUM_W-1:0] band_sum;
        logic             band_lit;
        logic             band_last;
    } band_item_t;

endpackage

### hw/rtl/band_energy_adaptive_trigger_core.sv
// Top level of the band energy adaptive trigger: bin accumulation, per-band
// threshold tracking and the output register, in one module.
// Depends on beat_pkg for item types, widths and register indexes.
`timescale 1ns / 1ps

// How the block is used
// ---------------------
// Spectrum bins arrive on the bin channel (bin_valid, bin_stall, bin_data), one
// bin per item. Each run of bins_per_band bins is summed into a band; at the end
// of a band that band's threshold is nudged up or down by the step, and a band
// item (band index, sum, lit flag, last flag) leaves on the band channel
// (band_valid, band_stall, band_data). Bins beyond the last band are dropped
// until frame_end; a frame_end bin that does not close a band discards the
// partial sum and restarts the frame at band 0.
// An accepted bin is held in an input register and handled when the output
// register can take a result; the add, the threshold update and both compares
// sit between the input register and the output register. One bin is taken in
// every cycle while bin_stall is low. When the receiver stalls, the output
// register holds its item and the input register fills; bin_stall rises only
// while both are full. Reset clears the counters, the accumulator, all
// thresholds and both valid flags, and loads the configuration defaults.
// Configuration is written through cfg_valid/cfg_ready (always ready); write it
// only while no bin is in flight, which the block itself leaves to the user.
module band_energy_adaptive_trigger_core #(
    parameter int BANDS             = 16,
    parameter int MAX_BINS_PER_BAND = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  bin_valid,
    output logic                                  bin_stall,
    input  beat_pkg::bin_item_t                   bin_data,

    output logic                                  band_valid,
    input  logic                                  band_stall,
    output beat_pkg::band_item_t                  band_data,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [beat_pkg::CFG_IW-1:0]           cfg_index,
    input  logic [beat_pkg::CFG_DW-1:0]           cfg_data
);

    // Band counter must hold BANDS itself (the "past the last band" state).
    localparam int BW  = $clog2(BANDS + 1);
    localparam int TIW = (BANDS > 1) ? $clog2(BANDS) : 1;
    // Bin counter holds values up to the band length.
    localparam int CW  = $clog2(MAX_BINS_PER_BAND + 1);
    localparam int LW  = (CW > beat_pkg::BPB_W) ? CW : beat_pkg::BPB_W;

    localparam logic [BW-1:0] LAST_BAND = BW'(BANDS - 1);
    localparam logic [BW-1:0] BAND_LIM  = BW'(BANDS);
    localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_BINS_PER_BAND);

    // Configuration registers.
    logic [beat_pkg::MARGIN_W-1:0] margin_reg;
    logic [beat_pkg::STEP_W-1:0]   step_reg;
    logic [beat_pkg::BPB_W-1:0]    bpb_reg;

    // Frame state.
    logic [beat_pkg::SUM_W-1:0]    acc_reg, acc_next;
    logic [CW-1:0]                 bin_cnt_reg, bin_cnt_next;
    logic [BW-1:0]                 band_cnt_reg, band_cnt_next;
    logic signed [beat_pkg::THR_W-1:0] thr_reg [BANDS];

    // Input and output registers.
    logic                          in_vld_reg;
    beat_pkg::bin_item_t           in_item_reg;
    logic                          out_vld_reg, out_vld_next;
    beat_pkg::band_item_t          out_item_reg;

    logic                          advance;
    logic                          accept;
    logic                          has_result;
    logic                          thr_we;
    logic [TIW-1:0]                thr_idx;

    logic [LW-1:0]                 bpb_ext;
    logic [CW-1:0]                 band_len;
    logic [beat_pkg::SUM_W:0]      sum_wide;
    logic [beat_pkg::SUM_W-1:0]    sum_sat;
    logic [CW:0]                   cnt_inc;
    logic signed [beat_pkg::CMP_W-1:0] sum_ext, thr_ext, thr_lim, thr_adj, thr_sat;
    logic signed [beat_pkg::THR_W-1:0] thr_new;
    logic                          lit;
    logic                          last;

    assign cfg_ready = 1'b1;

    // The input register moves on whenever the output register is free or
    // its item is being taken this cycle.
    assign advance   = !out_vld_reg || !band_stall;
    assign bin_stall = in_vld_reg && !advance;
    assign accept    = bin_valid && !bin_stall;

    assign band_valid = out_vld_reg;
    assign band_data  = out_item_reg;

    // Effective band length: zero acts as one, and it is clipped to the maximum.
    assign bpb_ext = LW'(bpb_reg);
    always_comb
    begin
        priority if (bpb_reg == '0)
            band_len = CW'(1);
        else if (bpb_ext > LEN_MAX)
            band_len = CW'(LEN_MAX);
        else
            band_len = CW'(bpb_ext);
    end

    // Saturating accumulation and bin count.
    assign sum_wide = {1'b0, acc_reg} + (beat_pkg::SUM_W + 1)'(in_item_reg.magnitude);
    assign sum_sat  = sum_wide[beat_pkg::SUM_W] ? beat_pkg::SUM_MAX
                                                : sum_wide[beat_pkg::SUM_W-1:0];
    assign cnt_inc  = {1'b0, bin_cnt_reg} + (CW + 1)'(1);

    // Threshold update for the band being closed.
    assign thr_idx = TIW'(band_cnt_reg);
    assign sum_ext = signed'(beat_pkg::CMP_W'(sum_sat));
    assign thr_ext = beat_pkg::CMP_W'(thr_reg[thr_idx]);
    assign thr_lim = thr_ext - signed'(beat_pkg::CMP_W'(margin_reg));

    always_comb
    begin
        if (sum_ext > thr_lim)
            thr_adj = thr_ext + signed'(beat_pkg::CMP_W'(step_reg));
        else
            thr_adj = thr_ext - signed'(beat_pkg::CMP_W'(step_reg));

        priority if (thr_adj > beat_pkg::THR_MAX)
            thr_sat = beat_pkg::THR_MAX;
        else if (thr_adj < beat_pkg::THR_MIN)
            thr_sat = beat_pkg::THR_MIN;
        else
            thr_sat = thr_adj;
    end

    assign thr_new = thr_sat[beat_pkg::THR_W-1:0];
    assign lit     = sum_ext > thr_sat;
    assign last    = in_item_reg.frame_end || (band_cnt_reg == LAST_BAND);

    // Frame control: what the bin in the input register does to the counters.
    always_comb
    begin
        acc_next      = acc_reg;
        bin_cnt_next  = bin_cnt_reg;
        band_cnt_next = band_cnt_reg;
        has_result    = 1'b0;

        if (in_vld_reg && advance)
        begin
            if (band_cnt_reg >= BAND_LIM)
            begin
                // Past the last band: wait for the end of the frame.
                if (in_item_reg.frame_end)
                begin
                    acc_next      = '0;
                    bin_cnt_next  = '0;
                    band_cnt_next = '0;
                end
            end
            else if (cnt_inc < (CW + 1)'(band_len))
            begin
                if (in_item_reg.frame_end)
                begin
                    acc_next      = '0;
                    bin_cnt_next  = '0;
                    band_cnt_next = '0;
                end
                else
                begin
                    acc_next     = sum_sat;
                    bin_cnt_next = cnt_inc[CW-1:0];
                end
            end
            else
            begin
                has_result   = 1'b1;
                acc_next     = '0;
                bin_cnt_next = '0;
                if (in_item_reg.frame_end)
                    band_cnt_next = '0;
                else
                    band_cnt_next = band_cnt_reg + BW'(1);
            end
        end
    end

    assign thr_we = has_result;

    always_comb
    begin
        if (advance)
            out_vld_next = in_vld_reg && has_result;
        else
            out_vld_next = out_vld_reg;
    end

    // Control state, configuration and thresholds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg   <= beat_pkg::MARGIN_RST;
            step_reg     <= beat_pkg::STEP_RST;
            bpb_reg      <= beat_pkg::BPB_RST;
            acc_reg      <= '0;
            bin_cnt_reg  <= '0;
            band_cnt_reg <= '0;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < BANDS; i++)
                thr_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    beat_pkg::CFG_MARGIN:
                        margin_reg <= cfg_data;
                    beat_pkg::CFG_STEP:
                        step_reg <= cfg_data[beat_pkg::STEP_W-1:0];
                    beat_pkg::CFG_BINS_PER_BAND:
                        bpb_reg <= cfg_data[beat_pkg::BPB_W-1:0];
                    default:
                        ;
                endcase
            end

            acc_reg      <= acc_next;
            bin_cnt_reg  <= bin_cnt_next;
            band_cnt_reg <= band_cnt_next;
            out_vld_reg  <= out_vld_next;

            if (accept)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (thr_we)
                thr_reg[thr_idx] <= thr_new;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= bin_data;

        if (advance && has_result)
        begin
            out_item_reg.band_index <= beat_pkg::IDX_W'(band_cnt_reg);
            out_item_reg.band_sum   <= sum_sat;
            out_item_reg.band_lit   <= lit;
            out_item_reg.band_last  <= last;
        end
    end

endmodule
